[rtl/lz4d_pkg.sv]
// Shared types and constants for the LZ4 block decompressor.
`timescale 1ns / 1ps

package lz4d_pkg;

    localparam int HISTORY_DEPTH = 65536;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int COUNT_BITS    = 24;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [HIST_AW-1:0]    t_haddr;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_COPY    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_BAD     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_TOKEN     = 3'd0,
        PH_LIT_EXT   = 3'd1,
        PH_LITERALS  = 3'd2,
        PH_OFF_LO    = 3'd3,
        PH_OFF_HI    = 3'd4,
        PH_MATCH_EXT = 3'd5,
        PH_COPY      = 3'd6,
        PH_DONE      = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SHORT    = 3'd1,
        ERR_OVERRUN  = 3'd2,
        ERR_ZERO_OFF = 3'd3,
        ERR_FAR_OFF  = 3'd4,
        ERR_BAD_CMD  = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_COPY  = 2'd1,
        ST_DONE  = 2'd2,
        ST_ERROR = 2'd3
    } t_status;

    // One decoded step, handed from the parser to the history stage.
    typedef struct packed {
        logic        emit;
        logic        is_copy;
        logic [7:0]  lit_byte;
        t_haddr      rd_addr;
        t_haddr      wr_addr;
        t_status     status;
        t_err        err;
        t_count      count;
    } t_step;

    // One finished result item.
    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        t_status     status;
        t_err        err;
        t_count      count;
    } t_result;

endpackage

[rtl/lz4d_parser.sv]
// Token/length/offset parser holding the per-block control state.
`timescale 1ns / 1ps

module lz4d_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [23:0]     i_cfg_data,
    input  logic            i_accept,
    input  logic [1:0]      i_command,
    input  logic [7:0]      i_in_byte,
    input  logic            i_is_last,
    output lz4d_pkg::t_step o_step
);
    import lz4d_pkg::*;

    function automatic t_count sat_add(input t_count a, input logic [8:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {{(COUNT_BITS-8){1'b0}}, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    t_count      r_cap;
    t_phase      r_phase,    n_phase;
    t_count      r_lit,      n_lit;
    t_count      r_ml,       n_ml;
    logic [3:0]  r_nib,      n_nib;
    logic [7:0]  r_off_lo,   n_off_lo;
    logic [15:0] r_off,      n_off;
    t_count      r_wc,       n_wc;
    t_err        r_err,      n_err;

    t_cmd                cmd;
    logic                lit_rdy, ml_rdy, emit, is_copy, over;
    t_count              wc_inc, chk_len;
    logic [COUNT_BITS:0] room_sum;
    t_status             status;

    assign cmd    = t_cmd'(i_command);
    assign wc_inc = (r_wc == {COUNT_BITS{1'b1}}) ? r_wc : r_wc + t_count'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= t_count'(HISTORY_DEPTH);
        end else if (i_cfg_we) begin
            r_cap <= t_count'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TOKEN;
            r_lit    <= '0;
            r_ml     <= '0;
            r_nib    <= '0;
            r_off_lo <= '0;
            r_off    <= '0;
            r_wc     <= '0;
            r_err    <= ERR_NONE;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_lit    <= n_lit;
            r_ml     <= n_ml;
            r_nib    <= n_nib;
            r_off_lo <= n_off_lo;
            r_off    <= n_off;
            r_wc     <= n_wc;
            r_err    <= n_err;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_lit    = r_lit;
        n_ml     = r_ml;
        n_nib    = r_nib;
        n_off_lo = r_off_lo;
        n_off    = r_off;
        n_wc     = r_wc;
        n_err    = r_err;
        lit_rdy  = 1'b0;
        ml_rdy   = 1'b0;
        emit     = 1'b0;
        is_copy  = 1'b0;

        if (cmd == CMD_RESTART) begin
            n_phase  = PH_TOKEN;
            n_lit    = '0;
            n_ml     = '0;
            n_nib    = '0;
            n_off_lo = '0;
            n_off    = '0;
            n_wc     = '0;
            n_err    = ERR_NONE;
        end else if (r_err == ERR_NONE && r_phase != PH_DONE) begin
            case (cmd)
                CMD_BAD: begin
                    n_err = ERR_BAD_CMD;
                end
                CMD_COPY: begin
                    if (r_phase == PH_COPY) begin
                        emit    = 1'b1;
                        is_copy = 1'b1;
                        n_wc    = wc_inc;
                        n_ml    = r_ml - t_count'(1);
                        if (r_ml == t_count'(1)) n_phase = PH_TOKEN;
                    end
                end
                CMD_BYTE: begin
                    case (r_phase)
                        PH_TOKEN: begin
                            n_nib = i_in_byte[3:0];
                            n_lit = t_count'(i_in_byte[7:4]);
                            if (i_in_byte[7:4] == 4'hF) begin
                                if (i_is_last) n_err = ERR_SHORT;
                                else n_phase = PH_LIT_EXT;
                            end else begin
                                lit_rdy = 1'b1;
                            end
                        end
                        PH_LIT_EXT: begin
                            n_lit = sat_add(r_lit, {1'b0, i_in_byte});
                            if (i_in_byte == 8'hFF) begin
                                if (i_is_last) n_err = ERR_SHORT;
                            end else begin
                                lit_rdy = 1'b1;
                            end
                        end
                        PH_LITERALS: begin
                            if (i_is_last && r_lit > t_count'(1)) begin
                                n_err = ERR_SHORT;
                            end else begin
                                emit  = 1'b1;
                                n_wc  = wc_inc;
                                n_lit = r_lit - t_count'(1);
                                if (r_lit == t_count'(1))
                                    n_phase = i_is_last ? PH_DONE : PH_OFF_LO;
                            end
                        end
                        PH_OFF_LO: begin
                            n_off_lo = i_in_byte;
                            if (i_is_last) n_err = ERR_SHORT;
                            else n_phase = PH_OFF_HI;
                        end
                        PH_OFF_HI: begin
                            n_off = {i_in_byte, r_off_lo};
                            if (n_off == 16'd0) begin
                                n_err = ERR_ZERO_OFF;
                            end else if (t_count'(n_off) > r_wc) begin
                                n_err = ERR_FAR_OFF;
                            end else if (r_nib == 4'hF) begin
                                n_ml = t_count'(15);
                                if (i_is_last) n_err = ERR_SHORT;
                                else n_phase = PH_MATCH_EXT;
                            end else begin
                                n_ml   = t_count'(r_nib) + t_count'(4);
                                ml_rdy = 1'b1;
                            end
                        end
                        PH_MATCH_EXT: begin
                            if (i_in_byte == 8'hFF) begin
                                n_ml = sat_add(r_ml, 9'd255);
                                if (i_is_last) n_err = ERR_SHORT;
                            end else begin
                                // byte plus the minimum match of four, saturating once
                                n_ml   = sat_add(r_ml, {1'b0, i_in_byte} + 9'd4);
                                ml_rdy = 1'b1;
                            end
                        end
                        default: begin
                            n_err = ERR_BAD_CMD;   // byte while a copy is pending
                        end
                    endcase
                end
                default: ;
            endcase
        end

        chk_len  = lit_rdy ? n_lit : n_ml;
        room_sum = {1'b0, r_wc} + {1'b0, chk_len};
        over     = room_sum > {1'b0, r_cap};

        if (lit_rdy) begin
            if (over) n_err = ERR_OVERRUN;
            else if (n_lit == '0) n_phase = i_is_last ? PH_DONE : PH_OFF_LO;
            else if (i_is_last) n_err = ERR_SHORT;
            else n_phase = PH_LITERALS;
        end
        if (ml_rdy) begin
            if (over) n_err = ERR_OVERRUN;
            else if (i_is_last) n_err = ERR_SHORT;
            else n_phase = PH_COPY;
        end

        if (n_err != ERR_NONE) status = ST_ERROR;
        else if (n_phase == PH_DONE) status = ST_DONE;
        else if (n_phase == PH_COPY) status = ST_COPY;
        else status = ST_RUN;
    end

    assign o_step.emit     = emit;
    assign o_step.is_copy  = is_copy;
    assign o_step.lit_byte = i_in_byte;
    assign o_step.rd_addr  = r_wc[HIST_AW-1:0] - r_off[HIST_AW-1:0];
    assign o_step.wr_addr  = r_wc[HIST_AW-1:0];
    assign o_step.status   = status;
    assign o_step.err      = n_err;
    assign o_step.count    = n_wc;

endmodule

[rtl/lz4d_history.sv]
// History window memory with the read/write-back stage and offset-one forwarding.
`timescale 1ns / 1ps

module lz4d_history (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_adv,
    input  lz4d_pkg::t_step   i_step,
    output lz4d_pkg::t_result o_res
);
    import lz4d_pkg::*;

    logic [7:0] mem [HISTORY_DEPTH];

    t_step      r_st;
    logic [7:0] r_rdata;
    logic [7:0] r_last_wr;
    logic       r_fwd;
    logic [7:0] copy_byte, wdata;
    logic       hit;

    // The entry being written back this cycle is not yet visible to the read.
    assign hit       = i_adv && r_st.emit && (r_st.wr_addr == i_step.rd_addr);
    assign copy_byte = r_fwd ? r_last_wr : r_rdata;
    assign wdata     = r_st.is_copy ? copy_byte : r_st.lit_byte;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rdata <= mem[i_step.rd_addr];
            r_st    <= i_step;
            r_fwd   <= hit;
        end
        if (i_adv && r_st.emit) begin
            mem[r_st.wr_addr] <= wdata;
            r_last_wr         <= wdata;
        end
    end

    assign o_res.out_valid = r_st.emit;
    assign o_res.out_byte  = r_st.emit ? wdata : 8'd0;
    assign o_res.status    = r_st.status;
    assign o_res.err       = r_st.err;
    assign o_res.count     = r_st.count;

endmodule

[rtl/lz4_block_decompressor.sv]
// Top level of the LZ4 block decompressor: handshakes, stage control, output register.
`timescale 1ns / 1ps
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_command, i_in_byte, i_is_last
//  res     | output    | o_res_valid / i_res_stall| o_out_valid, o_out_byte, o_status,
//          |           |                          | o_error_code, o_out_count
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_data (out_capacity)
//
//  One item per cycle sustained while the output is not stalled; each item gives one result
//  item, held first in the memory stage (parse + memory read), then in the output register (write-back).
//  The rate rests on the history memory: one read at acceptance and one write when the item
//  leaves the memory stage, with a forward for a copy at offset one.
//  Synchronous active-low reset clears control state and sets out_capacity to 65536;
//  the history memory is not cleared (no clearing pass).
//  A stalled output holds the output register; the item behind it waits in the memory
//  stage and the input then stalls.

module lz4_block_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_in_byte,
    input  logic        i_is_last,
    // result items
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic [2:0]  o_error_code,
    output logic [23:0] o_out_count,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);
    import lz4d_pkg::*;

    t_step   step;
    t_result s1_res;
    t_result r_out;
    logic    r_s1_valid, n_s1_valid;
    logic    r_out_valid, n_out_valid;
    logic    out_free, adv, accept;

    // Output register free when empty or being taken this cycle.
    assign out_free   = !r_out_valid || !i_res_stall;
    assign adv        = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    lz4d_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_command  (i_command),
        .i_in_byte  (i_in_byte),
        .i_is_last  (i_is_last),
        .o_step     (step)
    );

    lz4d_history u_history (
        .i_clk  (i_clk),
        .i_load (accept),
        .i_adv  (adv),
        .i_step (step),
        .o_res  (s1_res)
    );

    always_comb begin
        n_s1_valid  = accept || (r_s1_valid && !adv);
        n_out_valid = adv || (r_out_valid && i_res_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_out <= s1_res;
    end

    assign o_res_valid  = r_out_valid;
    assign o_out_valid  = r_out.out_valid;
    assign o_out_byte   = r_out.out_byte;
    assign o_status     = r_out.status;
    assign o_error_code = r_out.err;
    assign o_out_count  = r_out.count;

    // stall toward the input only while both stages are full and the output is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_res_stall))
        else $error("input stalled without a full pipeline");

    // an item leaving the memory stage always lands in the output register
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("item lost between memory stage and output");

    // an accepted item is held in the memory stage on the next cycle
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted item dropped");

    // error status always carries a code
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_ERROR) |-> (r_out.err != ERR_NONE))
        else $error("error status with no error code");

endmodule

[sim/tb.sv]
// Testbench for the LZ4 block decompressor: directed cases and random LZ4 blocks checked against a local decoder.
`timescale 1ns / 1ps

module tb;
    import lz4d_pkg::*;

    localparam logic [31:0] COUNT_LIMIT      = (32'd1 << COUNT_BITS) - 1;
    localparam int unsigned RUN_LIMIT_CYCLES = 3_000_000;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
        logic       last;
    } t_lz_item;

    // DUT ports; the inputs are all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_command   = CMD_BYTE;
    logic [7:0]  i_in_byte   = 8'h00;
    logic        i_is_last   = 1'b0;
    logic        o_res_valid;
    logic        i_res_stall = 1'b0;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_status;
    logic [2:0]  o_error_code;
    logic [23:0] o_out_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data  = 24'd0;

    lz4_block_decompressor dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_in_byte    (i_in_byte),
        .i_is_last    (i_is_last),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_error_code (o_error_code),
        .o_out_count  (o_out_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Decoder state mirror
    // ------------------------------------------------------------------
    t_phase     dec_phase;
    t_count     lit_left;
    t_count     match_left;
    t_count     produced;
    t_count     out_cap;
    logic [3:0] match_nib;
    logic [7:0] off_lo;
    logic [15:0] match_off;
    t_err       err_latch;
    logic [7:0] window [0:HISTORY_DEPTH-1];

    int err_hits [0:7];
    int blocks_done = 0;

    function automatic t_count sat_add(t_count a, int unsigned b);
        logic [31:0] s;
        s = {8'd0, a} + b;
        return (s > COUNT_LIMIT) ? t_count'(COUNT_LIMIT) : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic over_cap(t_count len);
        return ({8'd0, produced} + {8'd0, len}) > {8'd0, out_cap};
    endfunction

    function automatic void latch_err(t_err code);
        if (err_latch == ERR_NONE) begin
            err_latch = code;
            err_hits[code]++;
        end
    endfunction

    function automatic void restart_block();
        dec_phase  = PH_TOKEN;
        lit_left   = '0;
        match_left = '0;
        match_nib  = 4'd0;
        off_lo     = 8'd0;
        match_off  = 16'd0;
        produced   = '0;
        err_latch  = ERR_NONE;
    endfunction

    function automatic void store_byte(logic [7:0] b);
        window[produced[15:0]] = b;
        produced = sat_add(produced, 1);
    endfunction

    function automatic void lits_known(logic last);
        if (over_cap(lit_left)) begin
            latch_err(ERR_OVERRUN);
        end else if (lit_left == 0) begin
            dec_phase = last ? PH_DONE : PH_OFF_LO;
        end else if (last) begin
            latch_err(ERR_SHORT);
        end else begin
            dec_phase = PH_LITERALS;
        end
    endfunction

    function automatic void match_known(logic last);
        if (over_cap(match_left)) latch_err(ERR_OVERRUN);
        else if (last) latch_err(ERR_SHORT);
        else dec_phase = PH_COPY;
    endfunction

    // Advance the mirror by one input item and return the result it must produce.
    function automatic t_result lz4_decode_step(t_cmd cmd, logic [7:0] b, logic last);
        t_result    r;
        logic [15:0] src;
        logic       was_done;
        r = '0;
        was_done = (dec_phase == PH_DONE);
        if (cmd == CMD_RESTART) begin
            restart_block();
        end else if (err_latch != ERR_NONE || dec_phase == PH_DONE) begin
            // finished or failed: only a restart leaves
        end else if (cmd == CMD_BAD) begin
            latch_err(ERR_BAD_CMD);
        end else if (cmd == CMD_COPY) begin
            if (dec_phase == PH_COPY) begin
                src = produced[15:0] - match_off;
                r.out_byte  = window[src];
                r.out_valid = 1'b1;
                store_byte(r.out_byte);
                match_left = match_left - t_count'(1);
                if (match_left == 0) dec_phase = PH_TOKEN;
            end
        end else begin
            case (dec_phase)
                PH_TOKEN: begin
                    match_nib = b[3:0];
                    lit_left  = {20'd0, b[7:4]};
                    if (b[7:4] == 4'hF) begin
                        if (last) latch_err(ERR_SHORT);
                        else dec_phase = PH_LIT_EXT;
                    end else begin
                        lits_known(last);
                    end
                end
                PH_LIT_EXT: begin
                    lit_left = sat_add(lit_left, {24'd0, b});
                    if (b == 8'hFF) begin
                        if (last) latch_err(ERR_SHORT);
                    end else begin
                        lits_known(last);
                    end
                end
                PH_LITERALS: begin
                    if (last && lit_left > 1) begin
                        latch_err(ERR_SHORT);
                    end else begin
                        r.out_byte  = b;
                        r.out_valid = 1'b1;
                        store_byte(b);
                        lit_left = lit_left - t_count'(1);
                        if (lit_left == 0) dec_phase = last ? PH_DONE : PH_OFF_LO;
                    end
                end
                PH_OFF_LO: begin
                    off_lo = b;
                    if (last) latch_err(ERR_SHORT);
                    else dec_phase = PH_OFF_HI;
                end
                PH_OFF_HI: begin
                    match_off = {b, off_lo};
                    if (match_off == 16'd0) begin
                        latch_err(ERR_ZERO_OFF);
                    end else if ({8'd0, match_off} > produced) begin
                        latch_err(ERR_FAR_OFF);
                    end else if (match_nib == 4'hF) begin
                        match_left = 24'd15;
                        if (last) latch_err(ERR_SHORT);
                        else dec_phase = PH_MATCH_EXT;
                    end else begin
                        match_left = {20'd0, match_nib} + 24'd4;
                        match_known(last);
                    end
                end
                PH_MATCH_EXT: begin
                    match_left = sat_add(match_left, {24'd0, b});
                    if (b == 8'hFF) begin
                        if (last) latch_err(ERR_SHORT);
                    end else begin
                        match_left = sat_add(match_left, 4);
                        match_known(last);
                    end
                end
                default: latch_err(ERR_BAD_CMD);   // byte while a copy is pending
            endcase
        end

        if (err_latch != ERR_NONE) r.status = ST_ERROR;
        else if (dec_phase == PH_DONE) r.status = ST_DONE;
        else if (dec_phase == PH_COPY) r.status = ST_COPY;
        else r.status = ST_RUN;
        r.err   = err_latch;
        r.count = produced;
        if (!was_done && dec_phase == PH_DONE) blocks_done++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    t_lz_item compressed_stream [$];   // items not yet offered
    t_lz_item block_buf [$];           // scratch while a block is built
    t_result  predicted_steps [$];     // results owed by the DUT, oldest first

    t_lz_item cur_item;
    logic     item_taken     = 1'b0;
    logic     steady_flow    = 1'b0;   // no gaps, no stalls
    int       items_accepted = 0;
    int       results_seen   = 0;
    int       mismatch_count = 0;

    task automatic flag_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("MISMATCH result %0d: %s got %0h want %0h", results_seen, field, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !item_taken) begin
            // stalled item holds
        end else if (gap_left != 0 && !steady_flow) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (compressed_stream.size() != 0) begin
            cur_item = compressed_stream.pop_front();
            i_in_valid <= 1'b1;
            i_command  <= cur_item.cmd;
            i_in_byte  <= cur_item.data;
            i_is_last  <= cur_item.last;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left--;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern in windows counted by a 6-bit counter, plus long hold-offs
    // ------------------------------------------------------------------
    int         hold_left    = 0;
    int         next_hold_at = 300;
    int         stall_mode   = 0;
    logic [5:0] stall_window = 6'd0;
    logic       stall_next;

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else if (!steady_flow && results_seen >= next_hold_at) begin
            // long hold so the pipeline fills and the input side stalls
            hold_left    = $urandom_range(100, 200);
            next_hold_at = results_seen + 900;
            stall_next   = 1'b1;
        end else begin
            if (stall_window == 6'd0) stall_mode = $urandom_range(0, 2);
            stall_window = stall_window + 6'd1;
            if (steady_flow || stall_mode == 0) stall_next = 1'b0;
            else if (stall_mode == 1) stall_next = ($urandom_range(0, 3) == 0);
            else stall_next = ($urandom_range(0, 9) < 7);
        end
        i_res_stall <= stall_next;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input acceptance, check on result acceptance
    // ------------------------------------------------------------------
    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_taken = 1'b0;
        end else begin
            item_taken = i_in_valid && !o_in_stall;
            if (item_taken) begin
                predicted_steps.push_back(
                    lz4_decode_step(cur_item.cmd, cur_item.data, cur_item.last));
                items_accepted++;
            end
            if (o_res_valid && !i_res_stall) begin
                results_seen++;
                if (predicted_steps.size() == 0) begin
                    flag_mismatch("result with none pending", o_out_count, 0);
                end else begin
                    want = predicted_steps.pop_front();
                    if (o_out_valid !== want.out_valid)
                        flag_mismatch("out_valid", o_out_valid, want.out_valid);
                    if (o_out_byte !== want.out_byte)
                        flag_mismatch("out_byte", o_out_byte, want.out_byte);
                    if (o_status !== want.status)
                        flag_mismatch("status", o_status, want.status);
                    if (o_error_code !== want.err)
                        flag_mismatch("error_code", o_error_code, want.err);
                    if (o_out_count !== want.count)
                        flag_mismatch("out_count", o_out_count, want.count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    task automatic send(t_cmd cmd, logic [7:0] data, logic last);
        compressed_stream.push_back('{cmd: cmd, data: data, last: last});
    endtask

    task automatic put_block(t_cmd cmd, logic [7:0] data, logic last);
        block_buf.push_back('{cmd: cmd, data: data, last: last});
    endtask

    function automatic t_lz_item random_item();
        t_lz_item r;
        r.cmd  = t_cmd'($urandom_range(0, 3));
        r.data = 8'($urandom_range(0, 255));
        r.last = ($urandom_range(0, 7) == 0);
        return r;
    endfunction

    // mostly short runs, some needing one extension byte, a few crossing 255
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 6);
        if (r < 95) return $urandom_range(7, 40);
        return $urandom_range(250, 300);
    endfunction

    function automatic logic [3:0] len_nibble(int n);
        return (n >= 15) ? 4'hF : n[3:0];
    endfunction

    task automatic put_len_ext(int n);
        int rem;
        if (n >= 15) begin
            rem = n - 15;
            while (rem >= 255) begin
                put_block(CMD_BYTE, 8'hFF, 1'b0);
                rem -= 255;
            end
            put_block(CMD_BYTE, rem[7:0], 1'b0);
        end
    endtask

    // Mostly well-formed block (a few broken offsets): sequences of literals + match, closing on a literal run.
    task automatic build_block();
        int         nseq, made, nlit, mlen, avail, offs, r;
        logic [7:0] tok;
        t_lz_item   tail;
        nseq = $urandom_range(1, 5);
        made = 0;
        block_buf.delete();
        for (int s = 0; s < nseq; s++) begin
            nlit = pick_len();
            mlen = 4 + pick_len();
            if (s < nseq - 1 && made + nlit == 0) nlit = 1;
            tok = {len_nibble(nlit), len_nibble(mlen - 4)};
            if (s == nseq - 1) tok[3:0] = 4'($urandom_range(0, 15));
            put_block(CMD_BYTE, tok, 1'b0);
            put_len_ext(nlit);
            repeat (nlit) put_block(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0);
            if (s < nseq - 1) begin
                avail = made + nlit;
                if (avail > 65535) avail = 65535;
                r = $urandom_range(0, 99);
                // a few broken offsets; otherwise lean on short, overlapping copies
                if (r < 3) offs = 0;
                else if (r < 6 && avail < 65535) offs = $urandom_range(avail + 1, 65535);
                else if (r < 60) offs = $urandom_range(1, (avail < 4) ? avail : 4);
                else offs = $urandom_range(1, avail);
                put_block(CMD_BYTE, offs[7:0], 1'b0);
                put_block(CMD_BYTE, offs[15:8], 1'b0);
                put_len_ext(mlen - 4);
                repeat (mlen)
                    put_block(CMD_COPY, 8'($urandom_range(0, 255)),
                              $urandom_range(0, 7) == 0);
                made += nlit + mlen;
            end
        end
        tail = block_buf[block_buf.size() - 1];
        tail.last = 1'b1;
        block_buf[block_buf.size() - 1] = tail;
    endtask

    task automatic add_random_blocks(int target);
        int       added, pos;
        t_lz_item tail;
        added = 0;
        while (added < target) begin
            build_block();
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    pos = $urandom_range(0, block_buf.size() - 1);
                    block_buf[pos] = random_item();
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                // cut the block short
                pos = $urandom_range(0, block_buf.size() - 1);
                while (block_buf.size() > pos + 1) block_buf.delete(block_buf.size() - 1);
                tail = block_buf[pos];
                tail.last = 1'b1;
                block_buf[pos] = tail;
            end
            send(CMD_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            foreach (block_buf[i]) compressed_stream.push_back(block_buf[i]);
            added += block_buf.size() + 1;
            // trailing noise, mostly ignored by a finished block
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) compressed_stream.push_back(random_item());
        end
    endtask

    // wait until every item is in and every result is out, then let the pipe settle
    task automatic drain();
        @(posedge i_clk);
        while (compressed_stream.size() != 0 || i_in_valid || predicted_steps.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(t_count value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        out_cap = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (err_hits[i]) err_hits[i] = 0;
        restart_block();
        out_cap = 24'd65536;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // token-only block completes; afterwards only a restart counts
        send(CMD_RESTART, 8'h00, 1'b0);
        send(CMD_BYTE,    8'h00, 1'b1);
        send(CMD_COPY,    8'h00, 1'b0);
        send(CMD_BAD,     8'h00, 1'b0);
        send(CMD_BYTE,    8'hFF, 1'b1);
        // one literal, offset-one match, then a byte while the copy is pending
        send(CMD_RESTART, 8'hFF, 1'b1);
        send(CMD_BYTE,    8'h11, 1'b0);
        send(CMD_BYTE,    8'hA5, 1'b0);
        send(CMD_BYTE,    8'h01, 1'b0);
        send(CMD_BYTE,    8'h00, 1'b0);
        send(CMD_COPY,    8'hFF, 1'b0);
        send(CMD_BYTE,    8'h5A, 1'b0);
        // stray copy step, then a zero offset
        send(CMD_RESTART, 8'h00, 1'b0);
        send(CMD_COPY,    8'h00, 1'b1);
        send(CMD_BYTE,    8'h00, 1'b0);
        send(CMD_BYTE,    8'h00, 1'b0);
        send(CMD_BYTE,    8'h00, 1'b0);
        // offset reaching before the block start
        send(CMD_RESTART, 8'h00, 1'b0);
        send(CMD_BYTE,    8'h00, 1'b0);
        send(CMD_BYTE,    8'hFF, 1'b0);
        send(CMD_BYTE,    8'hFF, 1'b0);
        // literal run cut short by is_last: nothing emitted
        send(CMD_RESTART, 8'h00, 1'b0);
        send(CMD_BYTE,    8'h20, 1'b0);
        send(CMD_BYTE,    8'h5A, 1'b1);
        drain();

        // zero capacity: overrun beats early end, token-only still completes
        set_capacity(24'd0);
        send(CMD_RESTART, 8'h00, 1'b0);
        send(CMD_BYTE,    8'h10, 1'b1);
        send(CMD_RESTART, 8'h00, 1'b0);
        send(CMD_BYTE,    8'h00, 1'b1);
        add_random_blocks(40);
        drain();

        set_capacity(24'd65536);
        add_random_blocks(450);
        drain();

        set_capacity(24'hFF_FFFF);
        add_random_blocks(300);
        drain();

        set_capacity(t_count'($urandom_range(20, 400)));
        add_random_blocks(300);
        drain();

        // a stretch with no idle cycles on either side
        steady_flow = 1'b1;
        set_capacity(24'hFF_FFFF);
        add_random_blocks(60);
        drain();
        steady_flow = 1'b0;

        set_capacity(24'd1);
        add_random_blocks(150);
        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d input items, %0d results, %0d completed blocks",
                 items_accepted, results_seen, blocks_done);
        $display("errors latched: short %0d overrun %0d zero-offset %0d far %0d bad-cmd %0d",
                 err_hits[ERR_SHORT], err_hits[ERR_OVERRUN], err_hits[ERR_ZERO_OFF],
                 err_hits[ERR_FAR_OFF], err_hits[ERR_BAD_CMD]);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // hard stop for a hung handshake
    initial begin
        #(RUN_LIMIT_CYCLES * 20);
        $display("simulation failed");
        $finish;
    end

endmodule
